// ===== rtl/core/itp_pkg.sv =====
package itp_pkg;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DIV   = 8'h2F;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    K_PASS,
    K_OPEN,
    K_CLOSE,
    K_OP
  } kind_t;

  typedef enum logic [2:0] {
    C_OPEN  = 3'd0,
    C_PLUS  = 3'd1,
    C_MINUS = 3'd2,
    C_MUL   = 3'd3,
    C_DIV   = 3'd4
  } code_t;

  typedef struct packed {
    kind_t       kind;
    code_t       code;
    logic [7:0]  sym;
    logic        eoe;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } st_t;

  function automatic logic [7:0] code_char(input code_t code);
    logic [7:0] ch;
    case (code)
      C_OPEN:  ch = CH_OPEN;
      C_PLUS:  ch = CH_PLUS;
      C_MINUS: ch = CH_MINUS;
      C_MUL:   ch = CH_MUL;
      C_DIV:   ch = CH_DIV;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] code_prec(input code_t code);
    logic [1:0] p;
    case (code)
      C_PLUS, C_MINUS: p = 2'd1;
      C_MUL, C_DIV:    p = 2'd2;
      default:         p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/itp_front.sv =====
module itp_front (
  input  logic           item_valid,
  output logic           item_ready,
  input  logic [7:0]     symbol,
  input  logic           end_of_expr,
  output logic           wr_valid,
  input  logic           wr_ready,
  output itp_pkg::cmd_t  wr_cmd
);
  import itp_pkg::*;

  assign wr_valid   = item_valid;
  assign item_ready = wr_ready;

  always_comb begin
    wr_cmd.kind = K_PASS;
    wr_cmd.code = C_OPEN;
    wr_cmd.sym  = symbol;
    wr_cmd.eoe  = end_of_expr;
    case (symbol)
      CH_OPEN: begin
        wr_cmd.kind = K_OPEN;
      end
      CH_CLOSE: begin
        wr_cmd.kind = K_CLOSE;
      end
      CH_PLUS: begin
        wr_cmd.kind = K_OP;
        wr_cmd.code = C_PLUS;
      end
      CH_MINUS: begin
        wr_cmd.kind = K_OP;
        wr_cmd.code = C_MINUS;
      end
      CH_MUL: begin
        wr_cmd.kind = K_OP;
        wr_cmd.code = C_MUL;
      end
      CH_DIV: begin
        wr_cmd.kind = K_OP;
        wr_cmd.code = C_DIV;
      end
      default: begin
        wr_cmd.kind = K_PASS;
      end
    endcase
  end

endmodule

// ===== rtl/core/itp_queue.sv =====
module itp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  itp_pkg::cmd_t  wr_cmd,
  output logic           rd_valid,
  input  logic           rd_ready,
  output itp_pkg::cmd_t  rd_cmd
);
  import itp_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (fill != FW'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_cmd   = entries[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + FW'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

// ===== rtl/core/itp_back.sv =====
module itp_back #(
  parameter int STACK_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  itp_pkg::cmd_t  q_cmd,
  output logic           result_valid,
  input  logic           result_ready,
  output logic [7:0]     out_symbol,
  output logic           out_valid,
  output logic           out_last,
  output logic           syntax_error
);
  import itp_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  code_t         mem [STACK_DEPTH];
  code_t         rd_data;
  logic [AW-1:0] rd_addr;
  logic          push_en;
  code_t         push_code;

  st_t           state, state_next;
  cmd_t          cmd, cmd_next;
  logic [CW-1:0] count, count_next;
  logic          err, err_next;
  logic          flush, flush_next;
  logic          hold_valid, hold_valid_next;
  logic [7:0]    hold_sym, hold_sym_next;
  logic          o_valid, o_valid_next;
  logic [7:0]    o_sym, o_sym_next;
  logic          o_sval, o_sval_next;
  logic          o_last, o_last_next;
  logic          o_err, o_err_next;

  logic          out_free;
  logic          emit_ok;
  logic          emit_req;
  logic [7:0]    emit_sym;
  logic          do_push;
  logic          item_done;
  logic          take;
  logic [7:0]    top_char;

  assign rd_addr      = AW'(count - CW'(1));
  assign top_char     = code_char(rd_data);
  assign out_free     = !o_valid || result_ready;
  assign emit_ok      = cmd.eoe ? (!hold_valid || out_free) : out_free;

  assign result_valid = o_valid;
  assign out_symbol   = o_sym;
  assign out_valid    = o_sval;
  assign out_last     = o_last;
  assign syntax_error = o_err;

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[AW'(count)] <= push_code;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next      = state;
    cmd_next        = cmd;
    count_next      = count;
    err_next        = err;
    flush_next      = flush;
    hold_valid_next = hold_valid;
    hold_sym_next   = hold_sym;
    o_valid_next    = o_valid;
    o_sym_next      = o_sym;
    o_sval_next     = o_sval;
    o_last_next     = o_last;
    o_err_next      = o_err;
    push_en         = 1'b0;
    push_code       = cmd.code;
    q_ready         = 1'b0;
    emit_req        = 1'b0;
    emit_sym        = top_char;
    do_push         = 1'b0;
    item_done       = 1'b0;
    take            = 1'b0;

    if (o_valid && result_ready) begin
      o_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        take = 1'b1;
      end
      ST_EXEC: begin
        case (cmd.kind)
          K_PASS: begin
            if (emit_ok) begin
              emit_req  = 1'b1;
              emit_sym  = cmd.sym;
              item_done = 1'b1;
            end
          end
          K_OPEN: begin
            push_code = C_OPEN;
            do_push   = 1'b1;
            item_done = 1'b1;
          end
          K_OP: begin
            if (count != '0) begin
              state_next = ST_READ;
            end else begin
              do_push   = 1'b1;
              item_done = 1'b1;
            end
          end
          K_CLOSE: begin
            if (count != '0) begin
              state_next = ST_READ;
            end else begin
              err_next  = 1'b1;
              item_done = 1'b1;
            end
          end
          default: begin
            item_done = 1'b1;
          end
        endcase
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (flush) begin
          if (emit_ok) begin
            emit_req   = 1'b1;
            count_next = count - CW'(1);
            state_next = (count == CW'(1)) ? ST_FINISH : ST_READ;
          end
        end else if (cmd.kind == K_CLOSE) begin
          if (rd_data == C_OPEN) begin
            count_next = count - CW'(1);
            item_done  = 1'b1;
          end else if (emit_ok) begin
            emit_req   = 1'b1;
            count_next = count - CW'(1);
            state_next = ST_EXEC;
          end
        end else begin
          if (code_prec(cmd.code) <= code_prec(rd_data)) begin
            if (emit_ok) begin
              emit_req   = 1'b1;
              count_next = count - CW'(1);
              state_next = ST_EXEC;
            end
          end else begin
            do_push   = 1'b1;
            item_done = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          o_valid_next    = 1'b1;
          o_sym_next      = hold_valid ? hold_sym : 8'h00;
          o_sval_next     = hold_valid;
          o_last_next     = 1'b1;
          o_err_next      = err;
          hold_valid_next = 1'b0;
          err_next        = 1'b0;
          count_next      = '0;
          take            = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (do_push) begin
      if (count == CW'(STACK_DEPTH)) begin
        err_next = 1'b1;
      end else begin
        push_en    = 1'b1;
        count_next = count + CW'(1);
      end
    end

    if (emit_req) begin
      if (cmd.eoe) begin
        if (hold_valid) begin
          o_valid_next = 1'b1;
          o_sym_next   = hold_sym;
          o_sval_next  = 1'b1;
          o_last_next  = 1'b0;
          o_err_next   = 1'b0;
        end
        hold_valid_next = 1'b1;
        hold_sym_next   = emit_sym;
      end else begin
        o_valid_next = 1'b1;
        o_sym_next   = emit_sym;
        o_sval_next  = 1'b1;
        o_last_next  = 1'b0;
        o_err_next   = 1'b0;
      end
    end

    if (item_done) begin
      if (cmd.eoe) begin
        if (count_next != '0) begin
          flush_next = 1'b1;
          state_next = ST_READ;
        end else begin
          state_next = ST_FINISH;
        end
      end else begin
        take = 1'b1;
      end
    end

    if (take) begin
      q_ready = 1'b1;
      if (q_valid) begin
        cmd_next   = q_cmd;
        flush_next = 1'b0;
        state_next = ST_EXEC;
      end else begin
        state_next = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      err        <= 1'b0;
      flush      <= 1'b0;
      hold_valid <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      err        <= err_next;
      flush      <= flush_next;
      hold_valid <= hold_valid_next;
      o_valid    <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    hold_sym <= hold_sym_next;
    o_sym    <= o_sym_next;
    o_sval   <= o_sval_next;
    o_last   <= o_last_next;
    o_err    <= o_err_next;
  end

endmodule

// ===== rtl/core/infix_to_postfix_converter.sv =====
// infix to postfix converter (shunting-yard)
// input channel: item_valid/item_ready with symbol and end_of_expr, one
// character per item; end_of_expr marks the last character of an expression
// output channel: result_valid/result_ready with out_symbol, out_valid,
// out_last and syntax_error; out_last marks the final result of an
// expression, which carries the error flag, and an end that neither pops
// nor passes a character gives one result with out_valid low
// a two-entry queue sits between the classifier and the stack engine, so
// characters keep being taken while the engine works or the receiver stalls
// engine steps: a pass-through, a '(' or an operator on an empty stack is
// handled in the exec state; an operator or ')' passes read and check for
// each stack entry it compares, back to exec after each pop; an end item
// then flushes the stack through read and check and marks the last result
// in the finish state; an idle engine picks up an item from the idle state
// a pass-through that is not an end goes through the queue and cmd register
// when the receiver stalls the engine stops at the first symbol it must
// output and the queue fills; item_ready drops once the queue is full
// reset empties the queue, the stack and the output register and clears the
// error flag
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [7:0] symbol,
  input  logic       end_of_expr,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] out_symbol,
  output logic       out_valid,
  output logic       out_last,
  output logic       syntax_error
);
  import itp_pkg::*;

  logic wr_valid;
  logic wr_ready;
  cmd_t wr_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  itp_front u_front (
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .symbol      (symbol),
    .end_of_expr (end_of_expr),
    .wr_valid    (wr_valid),
    .wr_ready    (wr_ready),
    .wr_cmd      (wr_cmd)
  );

  itp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_cmd   (wr_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_cmd        (q_cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_symbol   (out_symbol),
    .out_valid    (out_valid),
    .out_last     (out_last),
    .syntax_error (syntax_error)
  );

  a_empty_only_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !out_valid) |-> out_last)
    else $error("empty result not marked last");

  a_error_only_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !out_last) |-> !syntax_error)
    else $error("error flag on a result that is not last");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !out_valid) |-> (out_symbol == 8'h00))
    else $error("empty result carries a symbol");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!result_valid && !q_valid))
    else $error("reset left a result or queued item");

endmodule
